@@ hw/rtl/rpfa_pkg.sv @@
// Shared types, constants and helpers for the refcounted page frame allocator.
// Used by every RTL module of the block; depends on nothing.
`default_nettype none

package rpfa_pkg;

   localparam int NUM_PAGES  = 32768;
   localparam int PAGE_SHIFT = 12;
   localparam int REF_BITS   = 8;

   localparam int ADDR_W     = 27;
   localparam int CFG_W      = 16;
   localparam int RSP_REF_W  = 8;
   localparam int PAGE_W     = $clog2(NUM_PAGES);
   localparam int CNT_W      = $clog2(NUM_PAGES + 1);
   localparam int PFLD_W     = ADDR_W - PAGE_SHIFT;

   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int Q_DEPTH    = 2;
   localparam int Q_PTR_W    = $clog2(Q_DEPTH);
   localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

   localparam logic [1:0] OP_INIT  = 2'd0;
   localparam logic [1:0] OP_ALLOC = 2'd1;
   localparam logic [1:0] OP_FREE  = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_OOM   = 2'd1;
   localparam logic [1:0] ST_BAD   = 2'd2;
   localparam logic [1:0] ST_UNDER = 2'd3;

   localparam logic REG_FIRST_PAGE = 1'b0;
   localparam logic REG_TOP_PAGE   = 1'b1;

   typedef enum logic [2:0] {
      CMD_NOP   = 3'd0,
      CMD_INIT  = 3'd1,
      CMD_ALLOC = 3'd2,
      CMD_FREE  = 3'd3,
      CMD_BAD   = 3'd4
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [PAGE_W-1:0] page;
   } cmd_type;

   typedef struct packed {
      logic                 released;
      logic [1:0]           status;
      logic [RSP_REF_W-1:0] ref_count;
      logic [ADDR_W-1:0]    page_address;
   } rsp_type;

   // managed top: min(top_page, NUM_PAGES)
   function automatic logic [31:0] eff_top(input logic [CFG_W-1:0] top);
      logic [31:0] t;
      t = 32'(top);
      if (t < 32'(NUM_PAGES)) begin
         return t;
      end
      return 32'(NUM_PAGES);
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/refcounted_page_frame_allocator.sv @@
// Refcounted page frame allocator: config registers, front end, command queue, back end.
// Depends on rpfa_pkg, rpfa_front, rpfa_queue and rpfa_back.
// Back end takes one command at a time: bad address, unknown opcode or out of memory go straight
// to the result; free reads then writes the count; allocate pops the free stack, then updates the
// count; init walks all pages, one page a cycle. Requests pass the front register and queue first.
// Reset is synchronous; afterwards a pass over every page clears the count memory, req_tready low.
`default_nettype none

module refcounted_page_frame_allocator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // address[26:0], zero fill
   input  logic [rpfa_pkg::REQ_DATA_W-1:0] req_tdata,
   // opcode[1:0]
   input  logic [rpfa_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // page_address[26:0], ref_count[34:27], zero fill
   output logic [rpfa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status[1:0], released[2]
   output logic [rpfa_pkg::RSP_USER_W-1:0] rsp_tuser,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rpfa_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rpfa_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rpfa_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import rpfa_pkg::*;

   logic [CFG_W-1:0] first_ff, first_in;
   logic [CFG_W-1:0] top_ff, top_in;
   logic             csr_wr;
   logic             front_valid, front_ready, q_valid, q_ready, clearing, rsp_valid;
   cmd_type          front_cmd, q_cmd;
   rsp_type          rsp;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_TOP_PAGE) ? CSR_DATA_W'(top_ff)
                                                      : CSR_DATA_W'(first_ff);

   always_comb begin
      first_in = first_ff;
      top_in   = top_ff;
      if (csr_wr) begin
         if (csr_paddr[2] == REG_FIRST_PAGE) begin
            first_in = csr_pwdata[CFG_W-1:0];
         end else begin
            top_in = csr_pwdata[CFG_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= '0;
         top_ff   <= CFG_W'(32768);
      end else begin
         first_ff <= first_in;
         top_ff   <= top_in;
      end
   end

   rpfa_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_opcode  (req_tuser[1:0]),
      .req_address (req_tdata[ADDR_W-1:0]),
      .cfg_first   (first_ff),
      .cfg_top     (top_ff),
      .hold        (clearing),
      .cmd_valid   (front_valid),
      .cmd_ready   (front_ready),
      .cmd         (front_cmd)
   );

   rpfa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_cmd    (front_cmd),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_cmd   (q_cmd)
   );

   rpfa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg_first (first_ff),
      .cfg_top   (top_ff),
      .cmd_valid (q_valid),
      .cmd_ready (q_ready),
      .cmd       (q_cmd),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tvalid = rsp_valid;
   assign rsp_tdata  = RSP_DATA_W'({rsp.ref_count, rsp.page_address});
   assign rsp_tuser  = {rsp.released, rsp.status};

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_tready)
      else $error("request taken during count clearing pass");

   a_release_is_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp.released) |-> (rsp.status == ST_OK && rsp.ref_count == '0
                                         && rsp.page_address == '0))
      else $error("released result with non-zero payload or error status");

   a_error_payload_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp.status != ST_OK) |-> (rsp.page_address == '0
                                               && rsp.ref_count == '0 && !rsp.released))
      else $error("error result carries payload");

endmodule

`default_nettype wire

@@ hw/rtl/rpfa_front.sv @@
// Front end: takes request beats, decodes the opcode and range-checks free addresses.
// Depends on rpfa_pkg; feeds rpfa_queue with classified commands.
`default_nettype none

module rpfa_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_opcode,
   input  logic [rpfa_pkg::ADDR_W-1:0]  req_address,
   input  logic [rpfa_pkg::CFG_W-1:0]   cfg_first,
   input  logic [rpfa_pkg::CFG_W-1:0]   cfg_top,
   input  logic                         hold,
   output logic                         cmd_valid,
   input  logic                         cmd_ready,
   output rpfa_pkg::cmd_type            cmd
);
   import rpfa_pkg::*;

   logic                valid_ff, valid_in;
   cmd_type             cmd_ff, cmd_in;
   logic [PFLD_W-1:0]   page_fld;
   logic                bad;
   logic                accept;

   assign page_fld  = req_address[ADDR_W-1:PAGE_SHIFT];
   assign bad       = (req_address[PAGE_SHIFT-1:0] != '0)
                      || (32'(page_fld) < 32'(cfg_first))
                      || (32'(page_fld) >= eff_top(cfg_top));
   assign req_ready = !hold && (!valid_ff || cmd_ready);
   assign accept    = req_valid && req_ready;
   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

   always_comb begin
      cmd_in.page = PAGE_W'(page_fld);
      case (req_opcode)
         OP_INIT:  cmd_in.kind = CMD_INIT;
         OP_ALLOC: cmd_in.kind = CMD_ALLOC;
         OP_FREE:  cmd_in.kind = bad ? CMD_BAD : CMD_FREE;
         default:  cmd_in.kind = CMD_NOP;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (cmd_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/rpfa_queue.sv @@
// Short command queue between the front end and the back end.
// Depends on rpfa_pkg for the command type and depth.
`default_nettype none

module rpfa_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  rpfa_pkg::cmd_type in_cmd,
   output logic              out_valid,
   input  logic              out_ready,
   output rpfa_pkg::cmd_type out_cmd
);
   import rpfa_pkg::*;

   cmd_type              slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 push, pop;

   assign in_ready  = count_ff != Q_CNT_W'(Q_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_cmd   = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/rpfa_back.sv @@
// Back end: free stack and reference count memories with their sequencer and result register.
// Depends on rpfa_pkg; takes commands from rpfa_queue.
`default_nettype none

module rpfa_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [rpfa_pkg::CFG_W-1:0]  cfg_first,
   input  logic [rpfa_pkg::CFG_W-1:0]  cfg_top,
   input  logic                        cmd_valid,
   output logic                        cmd_ready,
   input  rpfa_pkg::cmd_type           cmd,
   output logic                        clearing,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output rpfa_pkg::rsp_type           rsp
);
   import rpfa_pkg::*;

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_INIT  = 6'b000100,
      S_STK   = 6'b001000,
      S_REF   = 6'b010000,
      S_EMIT  = 6'b100000
   } state_type;

   logic [PAGE_W-1:0]   stack_mem [NUM_PAGES];
   logic [REF_BITS-1:0] refs_mem  [NUM_PAGES];

   state_type           state_ff, state_in;
   logic [PAGE_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]    fc_ff, fc_in;
   cmd_kind_type        kind_ff, kind_in;
   logic [PAGE_W-1:0]   page_ff, page_in;
   rsp_type             res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff;
   logic [PAGE_W-1:0]   stack_rd_ff;
   logic [REF_BITS-1:0] refs_rd_ff;

   logic                stk_re, stk_we, ref_re, ref_we, load_rsp, last;
   logic [PAGE_W-1:0]   stk_ra, stk_wa, stk_wd, ref_ra, ref_wa;
   logic [REF_BITS-1:0] ref_wd, cnt_inc, cnt_dec;
   logic [CNT_W-1:0]    fc_dec;
   logic [31:0]         top_eff, init_n;

   assign last      = idx_ff == PAGE_W'(NUM_PAGES - 1);
   assign fc_dec    = fc_ff - 1'b1;
   assign cnt_inc   = (refs_rd_ff == '1) ? refs_rd_ff : refs_rd_ff + 1'b1;
   assign cnt_dec   = refs_rd_ff - 1'b1;
   assign top_eff   = eff_top(cfg_top);
   assign init_n    = (top_eff > 32'(cfg_first)) ? top_eff - 32'(cfg_first) : '0;
   assign clearing  = state_ff == S_CLEAR;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      fc_in     = fc_ff;
      kind_in   = kind_ff;
      page_in   = page_ff;
      res_in    = res_ff;
      cmd_ready = 1'b0;
      load_rsp  = 1'b0;
      stk_re    = 1'b0;
      stk_ra    = '0;
      stk_we    = 1'b0;
      stk_wa    = '0;
      stk_wd    = '0;
      ref_re    = 1'b0;
      ref_ra    = '0;
      ref_we    = 1'b0;
      ref_wa    = '0;
      ref_wd    = '0;
      case (state_ff)
         S_CLEAR: begin
            ref_we = 1'b1;
            ref_wa = idx_ff;
            idx_in = idx_ff + 1'b1;
            if (last) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               kind_in  = cmd.kind;
               page_in  = cmd.page;
               res_in   = '0;
               state_in = S_EMIT;
               case (cmd.kind)
                  CMD_INIT: begin
                     fc_in    = CNT_W'(init_n);
                     idx_in   = '0;
                     state_in = S_INIT;
                  end
                  CMD_ALLOC: begin
                     if (fc_ff == '0) begin
                        res_in.status = ST_OOM;
                     end else begin
                        fc_in    = fc_dec;
                        stk_re   = 1'b1;
                        stk_ra   = fc_dec[PAGE_W-1:0];
                        state_in = S_STK;
                     end
                  end
                  CMD_FREE: begin
                     ref_re   = 1'b1;
                     ref_ra   = cmd.page;
                     state_in = S_REF;
                  end
                  CMD_BAD: begin
                     res_in.status = ST_BAD;
                  end
                  default: begin
                     res_in = '0;
                  end
               endcase
            end
         end
         S_INIT: begin
            ref_we = 1'b1;
            ref_wa = idx_ff;
            if (CNT_W'(idx_ff) < fc_ff) begin
               stk_we = 1'b1;
               stk_wa = idx_ff;
               stk_wd = PAGE_W'(32'(cfg_first) + 32'(idx_ff));
            end
            idx_in = idx_ff + 1'b1;
            if (last) begin
               idx_in   = '0;
               state_in = S_EMIT;
            end
         end
         S_STK: begin
            page_in  = stack_rd_ff;
            ref_re   = 1'b1;
            ref_ra   = stack_rd_ff;
            state_in = S_REF;
         end
         S_REF: begin
            state_in = S_EMIT;
            ref_wa   = page_ff;
            if (kind_ff == CMD_ALLOC) begin
               ref_we              = 1'b1;
               ref_wd              = cnt_inc;
               res_in.page_address = ADDR_W'(64'(page_ff) << PAGE_SHIFT);
               res_in.ref_count    = RSP_REF_W'(cnt_inc);
            end else if (refs_rd_ff == '0) begin
               res_in.status = ST_UNDER;
            end else begin
               ref_we = 1'b1;
               ref_wd = cnt_dec;
               if (cnt_dec == '0) begin
                  res_in.released = 1'b1;
                  if (fc_ff != CNT_W'(NUM_PAGES)) begin
                     stk_we = 1'b1;
                     stk_wa = fc_ff[PAGE_W-1:0];
                     stk_wd = page_ff;
                     fc_in  = fc_ff + 1'b1;
                  end
               end else begin
                  res_in.ref_count = RSP_REF_W'(cnt_dec);
               end
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         fc_ff        <= '0;
         kind_ff      <= CMD_NOP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         fc_ff        <= fc_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff <= page_in;
      res_ff  <= res_in;
      if (load_rsp) begin
         rsp_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stack_mem[stk_wa] <= stk_wd;
      end
      if (stk_re) begin
         stack_rd_ff <= stack_mem[stk_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (ref_we) begin
         refs_mem[ref_wa] <= ref_wd;
      end
      if (ref_re) begin
         refs_rd_ff <= refs_mem[ref_ra];
      end
   end

endmodule

`default_nettype wire

@@ sim/tb_refcounted_page_frame_allocator.sv @@
// Self-checking testbench for the refcounted page frame allocator.
// Drives the request stream and the APB-style CSR port and checks every response beat
// against a behavioural model of the free-page stack and count table; depends on rpfa_pkg.
`timescale 1ns / 1ps

module tb_refcounted_page_frame_allocator;
   import rpfa_pkg::*;

   localparam logic [1:0] OP_UNKNOWN    = 2'd3;
   localparam int         SETTLE_CYCLES = 16;
   localparam int         STALL_LIMIT   = 400000;
   localparam int         REF_TOP       = (1 << REF_BITS) - 1;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic [REQ_USER_W-1:0] req_tuser   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // model of the pool
   logic [REF_BITS-1:0] ref_table [NUM_PAGES];
   logic [PAGE_W-1:0]   spare_pages [NUM_PAGES];
   int unsigned         spare_depth = 0;
   logic [CFG_W-1:0]    first_page_cfg = 16'd0;
   logic [CFG_W-1:0]    top_page_cfg = 16'd32768;
   logic [ADDR_W-1:0]   held_pages [$];

   rsp_type pending_outcomes [$];
   int      error_count = 0;
   int      send_beats  = 0;
   bit      send_calm   = 1'b1;
   int      take_beats  = 0;
   bit      take_calm   = 1'b1;
   int      hold_left   = 0;

   refcounted_page_frame_allocator DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),    // address[26:0], zero fill
      .req_tuser   (req_tuser),    // opcode[1:0]
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),    // page_address[26:0], ref_count[34:27], zero fill
      .rsp_tuser   (rsp_tuser),    // status[1:0], released[2]
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   function automatic int unsigned pool_limit();
      return (top_page_cfg < NUM_PAGES) ? int'(top_page_cfg) : NUM_PAGES;
   endfunction

   task automatic apply_page_op(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                                output rsp_type outcome);
      int unsigned page;
      int unsigned p;
      int unsigned cnt;
      int          k;
      outcome = '0;
      outcome.status = ST_OK;
      case (op)
         OP_INIT: begin
            for (p = 0; p < NUM_PAGES; p++) ref_table[p] = '0;
            spare_depth = 0;
            held_pages.delete();
            for (p = first_page_cfg; p < pool_limit(); p++) begin
               if (spare_depth < NUM_PAGES) begin
                  spare_pages[spare_depth] = PAGE_W'(p);
                  spare_depth++;
               end
            end
         end
         OP_ALLOC: begin
            if (spare_depth == 0) begin
               outcome.status = ST_OOM;
            end else begin
               spare_depth--;
               page = spare_pages[spare_depth];
               cnt = ref_table[page];
               if (cnt < REF_TOP) cnt++;
               ref_table[page] = REF_BITS'(cnt);
               outcome.page_address = ADDR_W'(page) << PAGE_SHIFT;
               outcome.ref_count = RSP_REF_W'(cnt);
               held_pages.push_back(outcome.page_address);
            end
         end
         OP_FREE: begin
            page = addr >> PAGE_SHIFT;
            if (addr[PAGE_SHIFT-1:0] != '0 || page < first_page_cfg || page >= pool_limit()) begin
               outcome.status = ST_BAD;
            end else if (ref_table[page] == '0) begin
               outcome.status = ST_UNDER;
            end else begin
               cnt = ref_table[page] - 1;
               ref_table[page] = REF_BITS'(cnt);
               if (cnt == 0) begin
                  if (spare_depth < NUM_PAGES) begin
                     spare_pages[spare_depth] = PAGE_W'(page);
                     spare_depth++;
                  end
                  outcome.released = 1'b1;
                  for (k = 0; k < held_pages.size(); k++) begin
                     if (held_pages[k] == addr) begin
                        held_pages.delete(k);
                        break;
                     end
                  end
               end else begin
                  outcome.ref_count = RSP_REF_W'(cnt);
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic send_page_op(input logic [1:0] op, input logic [ADDR_W-1:0] addr);
      rsp_type outcome;
      int      gap;
      if (send_beats % 40 == 0) send_calm = ($urandom_range(0, 2) == 0);
      send_beats++;
      gap = send_calm ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      apply_page_op(op, addr, outcome);
      pending_outcomes.push_back(outcome);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(addr);
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [CFG_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == REG_FIRST_PAGE) first_page_cfg = value;
      else top_page_cfg = value;
   endtask

   task automatic compare_outcome();
      rsp_type want;
      rsp_type got;
      got.page_address = rsp_tdata[ADDR_W-1:0];
      got.ref_count    = rsp_tdata[ADDR_W +: RSP_REF_W];
      got.status       = rsp_tuser[1:0];
      got.released     = rsp_tuser[2];
      if (pending_outcomes.size() == 0) begin
         $error("response beat with nothing outstanding");
         error_count++;
      end else begin
         want = pending_outcomes.pop_front();
         if (got.status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            error_count++;
         end
         if (got.page_address != want.page_address) begin
            $error("page_address: expected 0x%0h, got 0x%0h",
                   want.page_address, got.page_address);
            error_count++;
         end
         if (got.ref_count != want.ref_count) begin
            $error("ref_count: expected %0d, got %0d", want.ref_count, got.ref_count);
            error_count++;
         end
         if (got.released != want.released) begin
            $error("released: expected %0d, got %0d", want.released, got.released);
            error_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         compare_outcome();
         if (take_beats % 40 == 0) take_calm = ($urandom_range(0, 2) == 0);
         take_beats++;
         hold_left = take_calm ? 0 : $urandom_range(0, 16);
      end else if (hold_left > 0) begin
         hold_left--;
      end
      rsp_tready <= !reset && (hold_left == 0);
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   task automatic test_after_reset();
      send_page_op(OP_ALLOC, '0);
      send_page_op(OP_FREE, 27'h0000000);
      send_page_op(OP_FREE, 27'h0000FFF);
      send_page_op(OP_UNKNOWN, 27'h7FFFFFF);
      send_page_op(OP_INIT, 27'h7FFFFFF);
      send_page_op(OP_ALLOC, '0);
      send_page_op(OP_ALLOC, 27'h7FFFFFF);
      send_page_op(OP_FREE, 27'h7FFF000);
      send_page_op(OP_FREE, 27'h7FFF000);
      send_page_op(OP_FREE, 27'h7FFFFFF);
      send_page_op(OP_FREE, 27'h7FFE001);
      send_page_op(OP_ALLOC, '0);
      wait_for_results();
   endtask

   task automatic test_empty_pool();
      write_csr(REG_FIRST_PAGE, 16'd32768);
      write_csr(REG_TOP_PAGE, 16'd0);
      send_page_op(OP_INIT, '0);
      send_page_op(OP_ALLOC, '0);
      send_page_op(OP_FREE, 27'h0000000);
      send_page_op(OP_FREE, 27'h7FFF000);
      wait_for_results();
   endtask

   task automatic test_single_page();
      write_csr(REG_FIRST_PAGE, 16'd32767);
      write_csr(REG_TOP_PAGE, 16'd32768);
      send_page_op(OP_INIT, '0);
      send_page_op(OP_ALLOC, '0);
      send_page_op(OP_ALLOC, '0);
      send_page_op(OP_FREE, 27'h7FFF000);
      send_page_op(OP_FREE, 27'h7FFE000);
      send_page_op(OP_FREE, 27'h7FFF000);
      wait_for_results();
   endtask

   task automatic run_traffic_phase(input logic [CFG_W-1:0] first, input logic [CFG_W-1:0] top,
                                    input bit reload, input int beats);
      int                n;
      int                roll;
      int unsigned       page;
      logic [ADDR_W-1:0] addr;
      write_csr(REG_FIRST_PAGE, first);
      write_csr(REG_TOP_PAGE, top);
      if (reload) send_page_op(OP_INIT, ADDR_W'($urandom()));
      for (n = 0; n < beats; n++) begin
         // hold off until the pipeline is empty now and then
         if (n == beats / 2 || $urandom_range(0, 63) == 0) wait_for_results();
         roll = $urandom_range(0, 99);
         if (roll < 40) begin
            send_page_op(OP_ALLOC, ADDR_W'($urandom()));
         end else if (roll < 70 && held_pages.size() != 0) begin
            addr = held_pages[$urandom_range(0, held_pages.size() - 1)];
            send_page_op(OP_FREE, addr);
         end else if (roll < 80) begin
            if (first_page_cfg < pool_limit())
               page = $urandom_range(first_page_cfg, pool_limit() - 1);
            else
               page = $urandom_range(0, NUM_PAGES - 1);
            send_page_op(OP_FREE, ADDR_W'(page) << PAGE_SHIFT);
         end else if (roll < 85) begin
            page = $urandom_range(0, NUM_PAGES - 1);
            send_page_op(OP_FREE, ADDR_W'(page) << PAGE_SHIFT);
         end else if (roll < 97) begin
            send_page_op(OP_FREE, ADDR_W'($urandom()));
         end else begin
            send_page_op(OP_UNKNOWN, ADDR_W'($urandom()));
         end
      end
      wait_for_results();
   endtask

   task automatic test_random_traffic();
      run_traffic_phase(16'd0, 16'd32768, 1'b1, 250);
      run_traffic_phase(16'd100, 16'd116, 1'b1, 300);
      run_traffic_phase(16'd0, 16'd8, 1'b0, 150);
      run_traffic_phase(16'd32000, 16'd32768, 1'b1, 250);
      run_traffic_phase(16'd0, 16'd1, 1'b1, 200);
      run_traffic_phase(16'd1234, 16'd1300, 1'b1, 300);
      run_traffic_phase(16'd2, 16'd12, 1'b1, 250);
      run_traffic_phase(16'd0, 16'd32768, 1'b0, 200);
   endtask

   initial begin : main_sequence
      int unsigned p;
      for (p = 0; p < NUM_PAGES; p++) begin
         ref_table[p]   = '0;
         spare_pages[p] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_after_reset();
      test_empty_pool();
      test_single_page();
      test_random_traffic();
      wait_for_results();
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
